// ----- hdl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg - text console char engine shared definitions
// Screen geometry, word field widths, request/character codes, the command
// that travels from the front end to the executor, and the tab-stop helper.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_LEN   = (ROWS - 1) * COLUMNS;  // cells moved by a scroll

  // internal widths
  localparam int ADDR_W    = $clog2(CELL_COUNT);
  localparam int CUR_COL_W = $clog2(COLUMNS);
  localparam int CUR_ROW_W = $clog2(ROWS);
  localparam int COLX_W    = $clog2(COLUMNS + TAB_WIDTH + 1);  // column before wrap
  localparam int ROWX_W    = $clog2(ROWS + 1);                 // row before scroll
  localparam int TAB_STOPS = COLUMNS / TAB_WIDTH + 1;

  // word field widths
  localparam int REQ_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int LOC_W    = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // request types
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7F;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] addr;
    logic              idx_ok;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR
  } state_t;

  // next multiple of TAB_WIDTH above col; independent compares against
  // constant stops, smallest match wins
  function automatic logic [COLX_W-1:0] tab_stop(input logic [CUR_COL_W-1:0] col);
    logic [COLX_W-1:0] stop;
    stop = '0;
    for (int k = TAB_STOPS; k >= 1; k--) begin
      if (COLX_W'(k * TAB_WIDTH) > COLX_W'(col)) begin
        stop = COLX_W'(k * TAB_WIDTH);
      end
    end
    return stop;
  endfunction

endpackage

// ----- hdl/tcce_front.sv -----
// ----------------------------------------------------------------------------
// tcce_front - request decoder
// Accepts input words and turns each into one executor command.
// ----------------------------------------------------------------------------
module tcce_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcce_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                            q_valid,
  input  logic                            q_ready,
  output tcce_pkg::cmd_t                  q_cmd
);

  logic [tcce_pkg::REQ_W-1:0]   req_type;
  logic [tcce_pkg::CHAR_W-1:0]  char_code;
  logic [tcce_pkg::INDEX_W-1:0] cell_index;

  assign req_type   = in_tdata[1:0];
  assign char_code  = in_tdata[9:2];
  assign cell_index = in_tdata[20:10];

  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;

  always_comb begin
    q_cmd.ch     = char_code;
    q_cmd.addr   = tcce_pkg::ADDR_W'(cell_index);
    q_cmd.idx_ok = (32'(cell_index) < tcce_pkg::CELL_COUNT);
    priority if (req_type == tcce_pkg::REQ_CLEAR) begin
      q_cmd.op = tcce_pkg::OP_CLEAR;
    end else if (req_type == tcce_pkg::REQ_READ) begin
      q_cmd.op = tcce_pkg::OP_READ;
    end else if (req_type != tcce_pkg::REQ_PUT) begin
      q_cmd.op = tcce_pkg::OP_NOP;
    end else if (char_code == tcce_pkg::CH_BS) begin
      q_cmd.op = tcce_pkg::OP_BS;
    end else if (char_code == tcce_pkg::CH_TAB) begin
      q_cmd.op = tcce_pkg::OP_TAB;
    end else if (char_code == tcce_pkg::CH_CR) begin
      q_cmd.op = tcce_pkg::OP_CR;
    end else if (char_code == tcce_pkg::CH_LF) begin
      q_cmd.op = tcce_pkg::OP_LF;
    end else if (char_code >= tcce_pkg::CH_BLANK && char_code <= tcce_pkg::CH_PRINT_MAX) begin
      q_cmd.op = tcce_pkg::OP_PRINT;
    end else begin
      q_cmd.op = tcce_pkg::OP_NOP;
    end
  end

endmodule

// ----- hdl/tcce_queue.sv -----
// ----------------------------------------------------------------------------
// tcce_queue - command FIFO
// Short FIFO between decoder and executor so each side stalls on its own.
// ----------------------------------------------------------------------------
module tcce_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tcce_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tcce_pkg::cmd_t pop_cmd
);

  tcce_pkg::cmd_t entry_r [tcce_pkg::QUEUE_DEPTH];

  logic [tcce_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tcce_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tcce_pkg::Q_CNT_W-1:0] count_r, count_nxt;
  logic                         push, pop;

  assign push_ready = (count_r != tcce_pkg::Q_CNT_W'(tcce_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tcce_pkg::Q_PTR_W'(tcce_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tcce_pkg::Q_PTR_W'(tcce_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- hdl/tcce_back.sv -----
// ----------------------------------------------------------------------------
// tcce_back - command executor
// Owns the cell store, cursor and attribute; runs puts, reads, clears and
// scrolls, and holds the result word in an output register.
// ----------------------------------------------------------------------------
module tcce_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tcce_pkg::ATTR_W-1:0]      cfg_wr_data,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  tcce_pkg::cmd_t                   q_cmd,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tcce_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // cell store
  logic [tcce_pkg::CELL_W-1:0] mem [tcce_pkg::CELL_COUNT];
  logic                        mem_we, mem_re;
  logic [tcce_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [tcce_pkg::CELL_W-1:0] mem_wdata;
  logic [tcce_pkg::CELL_W-1:0] rd_data_r;

  tcce_pkg::state_t state_r, state_nxt;

  logic [tcce_pkg::CUR_COL_W-1:0] col_r, col_nxt;
  logic [tcce_pkg::CUR_ROW_W-1:0] row_r, row_nxt;
  logic [tcce_pkg::ATTR_W-1:0]    attr_r, attr_nxt;
  logic [tcce_pkg::ADDR_W-1:0]    cnt_r, cnt_nxt;
  logic                           pend_r, pend_nxt;
  logic [tcce_pkg::ADDR_W-1:0]    pend_addr_r, pend_addr_nxt;
  logic                           rd_ok_r, rd_ok_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [tcce_pkg::CUR_COL_W-1:0] out_col_r, out_col_nxt;
  logic [tcce_pkg::CUR_ROW_W-1:0] out_row_r, out_row_nxt;
  logic [tcce_pkg::CELL_W-1:0]    out_data_r, out_data_nxt;

  logic                           go;
  logic                           load;
  logic [tcce_pkg::CELL_W-1:0]    load_data;
  logic [tcce_pkg::CELL_W-1:0]    blank;

  // put path
  logic [tcce_pkg::COLX_W-1:0]    put_col_x;
  logic [tcce_pkg::ROWX_W-1:0]    put_row_x;
  logic [tcce_pkg::CUR_COL_W-1:0] put_col;
  logic [tcce_pkg::CUR_ROW_W-1:0] put_row;
  logic                           put_we;
  logic                           scroll_need;
  logic [tcce_pkg::ADDR_W-1:0]    put_addr;

  assign go      = (state_r == tcce_pkg::ST_IDLE) && q_valid && (!out_valid_r || out_tready);
  assign q_ready = go;
  assign blank   = {attr_r, tcce_pkg::CH_BLANK};
  assign put_addr = tcce_pkg::ADDR_W'(row_r * tcce_pkg::COLUMNS + col_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0,
                       out_data_r,
                       tcce_pkg::LOC_W'(out_row_r * tcce_pkg::COLUMNS + out_col_r),
                       tcce_pkg::OROW_W'(out_row_r),
                       tcce_pkg::OCOL_W'(out_col_r)};

  always_comb begin
    put_col_x = tcce_pkg::COLX_W'(col_r);
    put_row_x = tcce_pkg::ROWX_W'(row_r);
    put_we    = 1'b0;
    unique case (q_cmd.op)
      tcce_pkg::OP_BS: begin
        if (col_r != '0) begin
          put_col_x = tcce_pkg::COLX_W'(col_r) - tcce_pkg::COLX_W'(1);
        end
      end
      tcce_pkg::OP_TAB: put_col_x = tcce_pkg::tab_stop(col_r);
      tcce_pkg::OP_CR:  put_col_x = '0;
      tcce_pkg::OP_LF: begin
        put_col_x = '0;
        put_row_x = tcce_pkg::ROWX_W'(row_r) + tcce_pkg::ROWX_W'(1);
      end
      tcce_pkg::OP_PRINT: begin
        put_we    = 1'b1;
        put_col_x = tcce_pkg::COLX_W'(col_r) + tcce_pkg::COLX_W'(1);
      end
      tcce_pkg::OP_NOP, tcce_pkg::OP_CLEAR, tcce_pkg::OP_READ: ;
    endcase
    // wrap at the right edge
    if (put_col_x >= tcce_pkg::COLX_W'(tcce_pkg::COLUMNS)) begin
      put_col_x = '0;
      put_row_x = put_row_x + tcce_pkg::ROWX_W'(1);
    end
    scroll_need = (put_row_x >= tcce_pkg::ROWX_W'(tcce_pkg::ROWS));
    put_col     = tcce_pkg::CUR_COL_W'(put_col_x);
    put_row     = scroll_need ? tcce_pkg::CUR_ROW_W'(tcce_pkg::ROWS - 1) :
                                tcce_pkg::CUR_ROW_W'(put_row_x);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcce_pkg::ST_IDLE: begin
        if (go) begin
          if (q_cmd.op == tcce_pkg::OP_READ) begin
            state_nxt = tcce_pkg::ST_READ;
          end else if (q_cmd.op == tcce_pkg::OP_CLEAR) begin
            state_nxt = tcce_pkg::ST_CLEAR;
          end else if (scroll_need) begin
            state_nxt = tcce_pkg::ST_SCROLL;
          end
        end
      end
      tcce_pkg::ST_READ: state_nxt = tcce_pkg::ST_IDLE;
      tcce_pkg::ST_SCROLL: begin
        if (cnt_r == tcce_pkg::ADDR_W'(tcce_pkg::COPY_LEN)) begin
          state_nxt = tcce_pkg::ST_BLANK;
        end
      end
      tcce_pkg::ST_BLANK, tcce_pkg::ST_CLEAR: begin
        if (cnt_r == tcce_pkg::ADDR_W'(tcce_pkg::CELL_COUNT - 1)) begin
          state_nxt = tcce_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcce_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    attr_nxt      = cfg_wr_en ? cfg_wr_data : attr_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    rd_ok_nxt     = rd_ok_r;
    mem_we        = 1'b0;
    mem_waddr     = put_addr;
    mem_wdata     = {attr_r, q_cmd.ch};
    mem_re        = 1'b0;
    mem_raddr     = q_cmd.addr;
    load          = 1'b0;
    load_data     = '0;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      tcce_pkg::ST_IDLE: begin
        if (go) begin
          if (q_cmd.op == tcce_pkg::OP_READ) begin
            mem_re    = q_cmd.idx_ok;
            rd_ok_nxt = q_cmd.idx_ok;
          end else if (q_cmd.op == tcce_pkg::OP_CLEAR) begin
            col_nxt = '0;
            row_nxt = '0;
            cnt_nxt = '0;
          end else begin
            col_nxt = put_col;
            row_nxt = put_row;
            mem_we  = put_we;
            if (scroll_need) begin
              cnt_nxt  = '0;
              pend_nxt = 1'b0;
            end else begin
              load = 1'b1;
            end
          end
        end
      end
      tcce_pkg::ST_READ: begin
        load      = 1'b1;
        load_data = rd_ok_r ? rd_data_r : '0;
      end
      tcce_pkg::ST_SCROLL: begin
        // copy pipeline: read row below now, write it one row up next cycle
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = rd_data_r;
        end
        if (cnt_r != tcce_pkg::ADDR_W'(tcce_pkg::COPY_LEN)) begin
          mem_re        = 1'b1;
          mem_raddr     = tcce_pkg::ADDR_W'(cnt_r + tcce_pkg::COLUMNS);
          pend_nxt      = 1'b1;
          pend_addr_nxt = cnt_r;
          cnt_nxt       = cnt_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      tcce_pkg::ST_BLANK, tcce_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = blank;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == tcce_pkg::ADDR_W'(tcce_pkg::CELL_COUNT - 1)) begin
          load = 1'b1;
        end
      end
      default: ;
    endcase

    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_data_nxt = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_col_nxt   = col_nxt;
      out_row_nxt   = row_nxt;
      out_data_nxt  = load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcce_pkg::ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= tcce_pkg::ATTR_RESET;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      attr_r      <= attr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule

// ----- hdl/text_console_char_engine_top.sv -----
// ----------------------------------------------------------------------------
// text_console_char_engine_top - text console character engine
// 80x25 text screen: put, clear and read requests in, one cursor report out.
// ----------------------------------------------------------------------------
// Each accepted request word yields exactly one result word carrying the
// cursor column, row and linear location (row*80+col) after the request, plus
// the cell contents for a read (attribute in the high byte, character in the
// low byte; zero for every other request or an index past the last cell).
// A decoder classifies request words into commands and pushes them into a
// two-entry queue; an executor drains the queue against a single-port-write,
// registered-read cell store. Rate: a put (printable byte or cursor control)
// that does not scroll streams at one word per clock while reports are taken;
// a read passes through a read state for the registered store read. A clear
// writes every cell once. A put that pushes the cursor past the last row
// scrolls: 1920 pipelined cell copies, a drain of the last copy and 80
// blanking writes. The executor works on one command at a time; the queue
// and the result register keep the input side accepting while a result
// waits, until the queue is full. Cells are undefined after reset and must
// be cleared before they are read. The attribute register (reset 0x0F)
// colors printed characters and blank cells; write it only while idle.
// ----------------------------------------------------------------------------
module text_console_char_engine_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration: text attribute byte
  input  logic                             cfg_wr_en,
  input  logic [tcce_pkg::ATTR_W-1:0]      cfg_wr_data,
  // request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] req_type, [9:2] char_code, [20:10] cell_index, [23:21] zero
  input  logic [tcce_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_location,
  // [38:23] cell_data, [39] zero
  output logic [tcce_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // decoder -> queue
  logic           dec_valid;
  logic           dec_ready;
  tcce_pkg::cmd_t dec_cmd;

  // queue -> executor
  logic           q_valid;
  logic           q_ready;
  tcce_pkg::cmd_t q_cmd;

  tcce_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (dec_valid),
    .q_ready   (dec_ready),
    .q_cmd     (dec_cmd)
  );

  tcce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (dec_valid),
    .push_ready (dec_ready),
    .push_cmd   (dec_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  tcce_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_cmd       (q_cmd),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ----- sim/text_console_char_engine_top_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_char_engine_top_tb - self-checking bench for the char engine
// Streams put/clear/read request words into the console engine and checks
// every cursor report against an in-bench screen model, across several text
// attribute settings and with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module text_console_char_engine_top_tb;

  localparam logic [tcce_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  // a clear or a scroll keeps the engine busy for about one screen of cells
  localparam int SETTLE_CYCLES = tcce_pkg::CELL_COUNT + 2 * tcce_pkg::COLUMNS;
  // longest stretch without any handshake before the run is declared hung
  localparam int HANG_LIMIT    = 20000;
  localparam int PHASE_WORDS   = 390;

  typedef struct {
    logic [tcce_pkg::REQ_W-1:0]   req;
    logic [tcce_pkg::CHAR_W-1:0]  ch;
    logic [tcce_pkg::INDEX_W-1:0] idx;
  } request_t;

  typedef struct {
    logic [tcce_pkg::OCOL_W-1:0] col;
    logic [tcce_pkg::OROW_W-1:0] row;
    logic [tcce_pkg::LOC_W-1:0]  loc;
    logic [tcce_pkg::CELL_W-1:0] data;
  } report_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [tcce_pkg::ATTR_W-1:0]      cfg_wr_data = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [tcce_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [tcce_pkg::OUT_TDATA_W-1:0] out_tdata;

  text_console_char_engine_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Screen model: cell store, cursor and attribute as the engine should hold
  // them. Updated once per accepted request word.
  // ---------------------------------------------------------------------------
  logic [tcce_pkg::CELL_W-1:0] screen_model [tcce_pkg::CELL_COUNT];
  int                          cur_col = 0;
  int                          cur_row = 0;
  logic [tcce_pkg::ATTR_W-1:0] attr_model = tcce_pkg::ATTR_RESET;

  request_t request_backlog [$];   // words waiting for the driver
  report_t  pending_reports [$];   // cursor reports still owed by the engine
  int       error_count = 0;
  bit       idle_en = 1'b1;        // random gaps/stalls allowed

  function automatic void console_apply(request_t w);
    report_t rpt;
    rpt.data = '0;
    case (w.req)
      tcce_pkg::REQ_PUT: begin
        if (w.ch == tcce_pkg::CH_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (w.ch == tcce_pkg::CH_TAB) begin
          cur_col = (cur_col / tcce_pkg::TAB_WIDTH + 1) * tcce_pkg::TAB_WIDTH;
        end else if (w.ch == tcce_pkg::CH_CR) begin
          cur_col = 0;
        end else if (w.ch == tcce_pkg::CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (w.ch >= tcce_pkg::CH_BLANK && w.ch <= tcce_pkg::CH_PRINT_MAX) begin
          screen_model[cur_row * tcce_pkg::COLUMNS + cur_col] = {attr_model, w.ch};
          cur_col++;
        end
        // bytes 0x80..0xFF and other controls fall through untouched
        if (cur_col >= tcce_pkg::COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= tcce_pkg::ROWS) begin
          // scroll up one line, blank the bottom line
          for (int i = 0; i < tcce_pkg::COPY_LEN; i++)
            screen_model[i] = screen_model[i + tcce_pkg::COLUMNS];
          for (int i = tcce_pkg::COPY_LEN; i < tcce_pkg::CELL_COUNT; i++)
            screen_model[i] = {attr_model, tcce_pkg::CH_BLANK};
          cur_row = tcce_pkg::ROWS - 1;
        end
      end
      tcce_pkg::REQ_CLEAR: begin
        for (int i = 0; i < tcce_pkg::CELL_COUNT; i++)
          screen_model[i] = {attr_model, tcce_pkg::CH_BLANK};
        cur_col = 0;
        cur_row = 0;
      end
      tcce_pkg::REQ_READ: begin
        if (w.idx < tcce_pkg::CELL_COUNT) rpt.data = screen_model[w.idx];
      end
      default: ;  // unused request type: cursor report only
    endcase
    rpt.col = tcce_pkg::OCOL_W'(cur_col);
    rpt.row = tcce_pkg::OROW_W'(cur_row);
    rpt.loc = tcce_pkg::LOC_W'(cur_row * tcce_pkg::COLUMNS + cur_col);
    pending_reports.push_back(rpt);
  endfunction

  // Mostly plausible console traffic: printable text with line control,
  // occasional reads, rare clears, plus junk bytes and the unused type.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    r.req = tcce_pkg::REQ_PUT;
    r.ch  = tcce_pkg::CHAR_W'($urandom_range(0, 255));
    r.idx = tcce_pkg::INDEX_W'($urandom_range(0, 2047));
    pick  = $urandom_range(0, 999);
    if (pick < 600) begin
      r.ch = tcce_pkg::CHAR_W'($urandom_range(tcce_pkg::CH_BLANK, tcce_pkg::CH_PRINT_MAX));
    end else if (pick < 700) begin
      r.ch = tcce_pkg::CH_LF;
    end else if (pick < 740) begin
      r.ch = tcce_pkg::CH_CR;
    end else if (pick < 790) begin
      r.ch = tcce_pkg::CH_BS;
    end else if (pick < 840) begin
      r.ch = tcce_pkg::CH_TAB;
    end else if (pick < 870) begin
      // any byte: high half, stray controls
    end else if (pick < 960) begin
      r.req = tcce_pkg::REQ_READ;
      if ($urandom_range(0, 15) != 0)
        r.idx = tcce_pkg::INDEX_W'($urandom_range(0, tcce_pkg::CELL_COUNT - 1));
    end else if (pick < 997) begin
      r.req = REQ_UNUSED;
    end else begin
      r.req = tcce_pkg::REQ_CLEAR;
    end
    return r;
  endfunction

  function automatic void queue_word(logic [tcce_pkg::REQ_W-1:0] req,
                                     logic [tcce_pkg::CHAR_W-1:0] ch,
                                     logic [tcce_pkg::INDEX_W-1:0] idx);
    request_t r;
    r.req = req;
    r.ch  = ch;
    r.idx = idx;
    request_backlog.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: one word held on in_tdata until accepted; the model is
  // advanced at the accepting edge.
  // ---------------------------------------------------------------------------
  request_t held_req;
  int       send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) console_apply(held_req);
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (request_backlog.size() > 0) begin
        held_req = request_backlog.pop_front();
        in_tdata  <= {3'b000, held_req.idx, held_req.ch, held_req.req};
        in_tvalid <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 11);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure in bursts
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 11);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every report word against the oldest owed report.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [tcce_pkg::CELL_W-1:0] want,
                                      logic [tcce_pkg::CELL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("report word with no request outstanding: %h", out_tdata);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("cursor_col", tcce_pkg::CELL_W'(want.col),
                    tcce_pkg::CELL_W'(out_tdata[6:0]));
        check_field("cursor_row", tcce_pkg::CELL_W'(want.row),
                    tcce_pkg::CELL_W'(out_tdata[11:7]));
        check_field("cursor_location", tcce_pkg::CELL_W'(want.loc),
                    tcce_pkg::CELL_W'(out_tdata[22:12]));
        check_field("cell_data", want.data, out_tdata[38:23]);
      end
    end
  end

  // hang detector: cycles without a handshake on either stream
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  // wait until the backlog is sent and every owed report has come back
  task automatic drain();
    while (request_backlog.size() != 0 || in_tvalid || pending_reports.size() != 0)
      @(posedge clk);
  endtask

  // attribute writes only with the engine idle, after the last report word
  task automatic write_attr(logic [tcce_pkg::ATTR_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    attr_model = value;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) request_backlog.push_back(random_request());
    drain();
  endtask

  initial begin
    for (int i = 0; i < tcce_pkg::CELL_COUNT; i++) screen_model[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: nothing may read the store before the first clear
    queue_word(REQ_UNUSED, 8'hFF, 11'h7FF);
    queue_word(tcce_pkg::REQ_READ, 8'h00, 11'h7FF);                   // past the last cell
    queue_word(tcce_pkg::REQ_READ, 8'hA5, 11'(tcce_pkg::CELL_COUNT)); // first index out
    queue_word(tcce_pkg::REQ_CLEAR, 8'h00, 11'h000);
    queue_word(tcce_pkg::REQ_READ, 8'h00, 11'h000);
    queue_word(tcce_pkg::REQ_READ, 8'h00, 11'(tcce_pkg::CELL_COUNT - 1));
    queue_word(tcce_pkg::REQ_PUT, 8'h41, 11'h000);
    queue_word(tcce_pkg::REQ_PUT, tcce_pkg::CH_PRINT_MAX, 11'h000);
    queue_word(tcce_pkg::REQ_PUT, tcce_pkg::CH_BLANK, 11'h000);
    queue_word(tcce_pkg::REQ_PUT, 8'h1F, 11'h000);                    // non-handled control
    queue_word(tcce_pkg::REQ_PUT, 8'h00, 11'h000);
    queue_word(tcce_pkg::REQ_PUT, 8'h80, 11'h000);                    // high half is ignored
    queue_word(tcce_pkg::REQ_PUT, 8'hFF, 11'h7FF);
    queue_word(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, 11'h000);
    queue_word(tcce_pkg::REQ_PUT, tcce_pkg::CH_CR, 11'h000);
    queue_word(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, 11'h000);          // backspace at column 0
    queue_word(tcce_pkg::REQ_PUT, tcce_pkg::CH_TAB, 11'h000);
    queue_word(tcce_pkg::REQ_PUT, tcce_pkg::CH_TAB, 11'h000);
    queue_word(tcce_pkg::REQ_PUT, tcce_pkg::CH_LF, 11'h000);
    queue_word(tcce_pkg::REQ_READ, 8'h00, 11'h000);
    queue_word(tcce_pkg::REQ_READ, 8'h00, 11'h001);
    queue_word(tcce_pkg::REQ_READ, 8'h00, 11'h002);
    drain();

    // random traffic under several attributes, extremes included
    random_phase(PHASE_WORDS);
    write_attr(8'hFF);
    random_phase(PHASE_WORDS);
    write_attr(8'h00);
    random_phase(PHASE_WORDS);
    write_attr(tcce_pkg::ATTR_W'($urandom_range(1, 254)));
    random_phase(PHASE_WORDS);
    write_attr(tcce_pkg::ATTR_W'($urandom_range(0, 255)));
    idle_en = 1'b0;                                 // full rate to the end
    random_phase(PHASE_WORDS);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/tcce_pkg.sv
hdl/tcce_front.sv
hdl/tcce_queue.sv
hdl/tcce_back.sv
hdl/text_console_char_engine_top.sv
sim/text_console_char_engine_top_tb.sv
